@@ rtl/tdl_pkg.sv @@
// Package for the tree distance / lowest common ancestor core.
// Holds field widths, the transfer structs, the opcode and state enums and unit structs.
// Has no dependencies; the core and tdl_unit import it, tdl_ram does not.
`default_nettype none

package tdl_pkg;

  localparam int unsigned NODE_W          = 10;
  localparam int unsigned DEPTH_W         = 10;
  localparam int unsigned DIST_W          = 11;
  localparam int unsigned SUM_W           = DIST_W + 1;
  localparam int unsigned MAX_LIFT_LEVELS = 18;
  localparam int unsigned LVL_IDX_W       = 5;
  localparam int unsigned STEP_W          = MAX_LIFT_LEVELS + 1;

  localparam int unsigned DEF_MAX_NODES   = 1024;
  localparam int unsigned DEF_LIFT_LEVELS = 10;

  localparam logic [DEPTH_W-1:0] DEPTH_MAX = {DEPTH_W{1'b1}};

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } tdl_op_e;

  typedef struct packed {
    tdl_op_e           operation;
    logic [NODE_W-1:0] node_a;
    logic [NODE_W-1:0] node_b;
  } tdl_in_t;

  typedef struct packed {
    logic [NODE_W-1:0] common_ancestor;
    logic [DIST_W-1:0] distance;
  } tdl_out_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LD_ROOT,
    S_LD_LVL,
    S_Q_DB,
    S_Q_ORD,
    S_P1_CHK,
    S_P1_ANC,
    S_P1_DEP,
    S_P1_END,
    S_P2_RV,
    S_P2_CMP,
    S_P2_PAR,
    S_C_DEP,
    S_OUT
  } tdl_state_e;

  typedef struct packed {
    logic [DEPTH_W-1:0]   depth_u;
    logic [DEPTH_W-1:0]   depth_v;
    logic [LVL_IDX_W-1:0] lvl;
    logic [NODE_W-1:0]    node_x;
    logic [NODE_W-1:0]    node_y;
    logic [DEPTH_W-1:0]   depth_a;
    logic [DEPTH_W-1:0]   depth_b;
    logic [DEPTH_W-1:0]   depth_c;
  } tdl_unit_in_t;

  typedef struct packed {
    logic               lift_ok;
    logic               nodes_equal;
    logic [DEPTH_W-1:0] depth_next;
    logic [DIST_W-1:0]  distance;
  } tdl_unit_out_t;

endpackage

`default_nettype wire

@@ rtl/tree_distance_lca_core.sv @@
// Tree distance core: lowest common ancestor by binary lifting, one item at a time.
// A load writes the depth and level 0 of its node, then each higher ancestor level in turn;
// a query walks both tables, and how soon its result comes is set by the single read port of each table.
// Reset clears control only; tables are not cleared, node 0 always reads as zero.
// Depends on tdl_pkg, tdl_ram and tdl_unit.
`default_nettype none

module tree_distance_lca_core #(
  parameter int unsigned MAX_NODES   = tdl_pkg::DEF_MAX_NODES,
  parameter int unsigned LIFT_LEVELS = tdl_pkg::DEF_LIFT_LEVELS
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  tdl_pkg::tdl_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output tdl_pkg::tdl_out_t out_data_o
);
  import tdl_pkg::*;

  // Table geometry. The ancestor table is addressed as {node, level}, so each
  // node owns a row of 2^LVL_W entries of which LIFT_LEVELS are used.
  localparam int unsigned IDX_W     = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int unsigned LVL_W     = (LIFT_LEVELS > 1) ? $clog2(LIFT_LEVELS) : 1;
  localparam int unsigned ANC_DEPTH = MAX_NODES * (2 ** LVL_W);
  localparam int unsigned ANC_AW    = IDX_W + LVL_W;
  localparam logic [LVL_W-1:0] TOP_LVL = LVL_W'(LIFT_LEVELS - 1);

  tdl_state_e state_q, state_d;

  // u and v are the two walking nodes. During a load u holds the node and v its parent.
  logic [NODE_W-1:0]  u_q, u_d, v_q, v_d;
  logic [NODE_W-1:0]  au_q, au_d;
  logic [NODE_W-1:0]  c_q, c_d;
  logic [DEPTH_W-1:0] du_q, du_d, dv_q, dv_d, da_q, da_d, db_q, db_d;
  logic [DIST_W-1:0]  dist_q, dist_d;
  logic [LVL_W-1:0]   lvl_q, lvl_d;

  // Read side flags, registered alongside the RAM reads.
  logic               dz_q, dz_d;
  logic               az_q, az_d;
  logic               fwd_q, fwd_d;
  logic [NODE_W-1:0]  fwd_data_q, fwd_data_d;

  // Table port controls.
  logic [NODE_W-1:0]  d_rnode, d_wnode, a_rnode, a_wnode;
  logic [LVL_W-1:0]   a_rlvl, a_wlvl;
  logic               d_we, a_we;
  logic [DEPTH_W-1:0] d_wdata, depth_rd, ddata_eff;
  logic [NODE_W-1:0]  a_wdata, anc_rd, adata_eff;

  tdl_unit_in_t  unit_in;
  tdl_unit_out_t unit_out;

  logic               in_fire;
  logic               out_free;
  logic               a_in_range, b_in_range, load_ok;
  logic [NODE_W-1:0]  a_idx, b_idx;
  logic               out_valid_q;
  tdl_out_t           out_data_q;

  // The block takes a new transfer only when the sequencer is idle.
  assign in_stall_o = (state_q != S_IDLE);
  assign in_fire    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // Nodes at or beyond MAX_NODES fold onto node 0; a load of such a node, or
  // of node 0 itself, is dropped so the sentinel stays zero.
  assign a_in_range = (32'(in_data_i.node_a) < MAX_NODES);
  assign b_in_range = (32'(in_data_i.node_b) < MAX_NODES);
  assign a_idx      = a_in_range ? in_data_i.node_a : '0;
  assign b_idx      = b_in_range ? in_data_i.node_b : '0;
  assign load_ok    = a_in_range && (in_data_i.node_a != '0);

  // Reads of node 0 return zero, and a load reads back the entry it writes in
  // the same cycle when its ancestor chain passes through the node itself.
  assign ddata_eff = dz_q ? '0 : depth_rd;
  assign adata_eff = fwd_q ? fwd_data_q : (az_q ? '0 : anc_rd);

  tdl_ram #(
    .WIDTH(DEPTH_W),
    .DEPTH(MAX_NODES)
  ) u_depth_ram (
    .clk_i  (clk_i),
    .we_i   (d_we),
    .waddr_i(IDX_W'(d_wnode)),
    .wdata_i(d_wdata),
    .raddr_i(IDX_W'(d_rnode)),
    .rdata_o(depth_rd)
  );

  tdl_ram #(
    .WIDTH(NODE_W),
    .DEPTH(ANC_DEPTH)
  ) u_anc_ram (
    .clk_i  (clk_i),
    .we_i   (a_we),
    .waddr_i(ANC_AW'({IDX_W'(a_wnode), a_wlvl})),
    .wdata_i(a_wdata),
    .raddr_i(ANC_AW'({IDX_W'(a_rnode), a_rlvl})),
    .rdata_o(anc_rd)
  );

  // Operand selection for the shared unit. The node compare serves the
  // read-back check of a load, the early exit of the first pass and the
  // ancestor compare of the second pass.
  always_comb begin
    unit_in.depth_u = du_q;
    unit_in.depth_v = dv_q;
    unit_in.lvl     = LVL_IDX_W'(lvl_q);
    unit_in.node_x  = u_q;
    unit_in.node_y  = v_q;
    unit_in.depth_a = da_q;
    unit_in.depth_b = db_q;
    unit_in.depth_c = ddata_eff;
    unique case (state_q)
      S_LD_ROOT: begin
        unit_in.depth_u = ddata_eff;
        unit_in.node_x  = v_q;
        unit_in.node_y  = u_q;
      end
      S_LD_LVL: begin
        unit_in.node_x = adata_eff;
        unit_in.node_y = u_q;
      end
      S_P2_CMP: begin
        unit_in.node_x = adata_eff;
        unit_in.node_y = au_q;
      end
      default: begin
      end
    endcase
  end

  tdl_unit u_unit (
    .unit_i(unit_in),
    .unit_o(unit_out)
  );

  // Sequencer next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          if (in_data_i.operation == OP_QUERY) begin
            state_d = S_Q_DB;
          end else if (load_ok) begin
            state_d = S_LD_ROOT;
          end
        end
      end
      S_LD_ROOT: state_d = (TOP_LVL == '0) ? S_IDLE : S_LD_LVL;
      S_LD_LVL:  state_d = (lvl_q == TOP_LVL) ? S_IDLE : S_LD_LVL;
      S_Q_DB:    state_d = S_Q_ORD;
      S_Q_ORD:   state_d = S_P1_CHK;
      S_P1_CHK: begin
        if (unit_out.lift_ok) begin
          state_d = S_P1_ANC;
        end else if (lvl_q == '0) begin
          state_d = S_P1_END;
        end
      end
      S_P1_ANC:  state_d = S_P1_DEP;
      S_P1_DEP:  state_d = (lvl_q == '0) ? S_P1_END : S_P1_CHK;
      S_P1_END:  state_d = unit_out.nodes_equal ? S_C_DEP : S_P2_RV;
      S_P2_RV:   state_d = S_P2_CMP;
      S_P2_CMP:  state_d = (lvl_q == '0) ? S_P2_PAR : S_P2_RV;
      S_P2_PAR:  state_d = S_C_DEP;
      S_C_DEP:   state_d = S_OUT;
      S_OUT:     state_d = out_free ? S_IDLE : S_OUT;
      default:   state_d = S_IDLE;
    endcase
  end

  // Sequencer outputs: table reads and writes and the working registers.
  always_comb begin
    u_d        = u_q;
    v_d        = v_q;
    au_d       = au_q;
    c_d        = c_q;
    du_d       = du_q;
    dv_d       = dv_q;
    da_d       = da_q;
    db_d       = db_q;
    dist_d     = dist_q;
    lvl_d      = lvl_q;
    fwd_d      = 1'b0;
    fwd_data_d = fwd_data_q;
    d_rnode    = u_q;
    a_rnode    = u_q;
    a_rlvl     = lvl_q;
    d_we       = 1'b0;
    d_wnode    = u_q;
    d_wdata    = unit_out.depth_next;
    a_we       = 1'b0;
    a_wnode    = u_q;
    a_wlvl     = lvl_q;
    a_wdata    = adata_eff;
    unique case (state_q)
      S_IDLE: begin
        // The first depth read goes out in the transfer cycle itself.
        d_rnode = (in_data_i.operation == OP_QUERY) ? a_idx : b_idx;
        if (in_fire) begin
          u_d = (in_data_i.operation == OP_QUERY) ? a_idx : in_data_i.node_a;
          v_d = b_idx;
        end
      end
      S_LD_ROOT: begin
        // Depth and level 0 are written; level 0 of the parent is read next.
        d_we       = 1'b1;
        a_we       = 1'b1;
        a_wlvl     = '0;
        a_wdata    = v_q;
        a_rnode    = v_q;
        a_rlvl     = '0;
        fwd_d      = unit_out.nodes_equal;
        fwd_data_d = v_q;
        lvl_d      = LVL_W'(1);
      end
      S_LD_LVL: begin
        a_we       = 1'b1;
        a_rnode    = adata_eff;
        a_rlvl     = lvl_q;
        fwd_d      = unit_out.nodes_equal;
        fwd_data_d = adata_eff;
        if (lvl_q != TOP_LVL) begin
          lvl_d = lvl_q + LVL_W'(1);
        end
      end
      S_Q_DB: begin
        da_d    = ddata_eff;
        d_rnode = v_q;
      end
      S_Q_ORD: begin
        // The deeper node walks first; ties keep the first node as u.
        db_d  = ddata_eff;
        lvl_d = TOP_LVL;
        if (da_q < ddata_eff) begin
          u_d  = v_q;
          du_d = ddata_eff;
          v_d  = u_q;
          dv_d = da_q;
        end else begin
          du_d = da_q;
          dv_d = ddata_eff;
        end
      end
      S_P1_CHK: begin
        a_rnode = u_q;
        a_rlvl  = lvl_q;
        if (!unit_out.lift_ok && (lvl_q != '0)) begin
          lvl_d = lvl_q - LVL_W'(1);
        end
      end
      S_P1_ANC: begin
        // The depth of the new node is read back rather than derived.
        u_d     = adata_eff;
        d_rnode = adata_eff;
      end
      S_P1_DEP: begin
        du_d = ddata_eff;
        if (lvl_q != '0) begin
          lvl_d = lvl_q - LVL_W'(1);
        end
      end
      S_P1_END: begin
        if (unit_out.nodes_equal) begin
          c_d     = u_q;
          d_rnode = u_q;
        end else begin
          lvl_d   = TOP_LVL;
          a_rnode = u_q;
          a_rlvl  = TOP_LVL;
        end
      end
      S_P2_RV: begin
        au_d    = adata_eff;
        a_rnode = v_q;
        a_rlvl  = lvl_q;
      end
      S_P2_CMP: begin
        // Step both nodes up when their ancestors differ, and issue the read
        // for the next level from the updated u.
        if (!unit_out.nodes_equal) begin
          u_d = au_q;
          v_d = adata_eff;
        end
        a_rnode = unit_out.nodes_equal ? u_q : au_q;
        if (lvl_q != '0) begin
          lvl_d  = lvl_q - LVL_W'(1);
          a_rlvl = lvl_q - LVL_W'(1);
        end else begin
          a_rlvl = '0;
        end
      end
      S_P2_PAR: begin
        c_d     = adata_eff;
        d_rnode = adata_eff;
      end
      S_C_DEP: begin
        dist_d = unit_out.distance;
      end
      S_OUT: begin
      end
      default: begin
      end
    endcase
  end

  assign dz_d = (d_rnode == '0);
  assign az_d = (a_rnode == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      lvl_q   <= '0;
      fwd_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      lvl_q   <= lvl_d;
      fwd_q   <= fwd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    u_q        <= u_d;
    v_q        <= v_d;
    au_q       <= au_d;
    c_q        <= c_d;
    du_q       <= du_d;
    dv_q       <= dv_d;
    da_q       <= da_d;
    db_q       <= db_d;
    dist_q     <= dist_d;
    dz_q       <= dz_d;
    az_q       <= az_d;
    fwd_data_q <= fwd_data_d;
  end

  // The output register parts the result from the sequencer, so a finished
  // query waits in S_OUT only while an earlier result is still stalled.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((state_q == S_OUT) && out_free) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == S_OUT) && out_free) begin
      out_data_q.common_ancestor <= c_q;
      out_data_q.distance        <= dist_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // The level counter never leaves the range of lift levels.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    lvl_q <= TOP_LVL)
    else $error("lift level counter out of range");

  // A result appears only when the sequencer hands one over.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_OUT))
    else $error("result raised outside the hand-over state");

  // A finished query is held while the previous result is stalled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT && out_valid_q && out_stall_i) |=> (state_q == S_OUT))
    else $error("result dropped while output stalled");

  // Read-back forwarding belongs to the load walk only.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fwd_q |-> (state_q == S_LD_LVL || state_q == S_IDLE))
    else $error("forwarded ancestor outside a load");

endmodule

`default_nettype wire

@@ rtl/tdl_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Standalone; used for the depth table and the ancestor table.
`default_nettype none

module tdl_ram #(
  parameter int unsigned WIDTH = 10,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ rtl/tdl_unit.sv @@
// Shared compare and arithmetic unit of the core: lift test, node compare,
// saturating depth increment and path length. Depends on tdl_pkg.
`default_nettype none

module tdl_unit (
  input  tdl_pkg::tdl_unit_in_t  unit_i,
  output tdl_pkg::tdl_unit_out_t unit_o
);
  import tdl_pkg::*;

  logic [STEP_W-1:0] step;
  logic [SUM_W-1:0]  sum_ab;
  logic [SUM_W-1:0]  twice_c;

  // A lift by 2^lvl is allowed when the lifted node stays at or below the other one.
  assign step = STEP_W'(1) << unit_i.lvl;
  assign unit_o.lift_ok = STEP_W'(unit_i.depth_u) >= (STEP_W'(unit_i.depth_v) + step);

  assign unit_o.nodes_equal = (unit_i.node_x == unit_i.node_y);

  assign unit_o.depth_next = (unit_i.depth_u == DEPTH_MAX) ? DEPTH_MAX
                                                           : unit_i.depth_u + DEPTH_W'(1);

  // Inconsistent tables could make the path length negative; it is clamped to zero.
  assign sum_ab  = SUM_W'(unit_i.depth_a) + SUM_W'(unit_i.depth_b);
  assign twice_c = {1'b0, unit_i.depth_c, 1'b0};
  assign unit_o.distance = (sum_ab < twice_c) ? '0 : DIST_W'(sum_ab - twice_c);

endmodule

`default_nettype wire
